// ===== sv/s2x_pkg.sv =====
`default_nettype none

package s2x_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int PIX_W       = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WCFG_W      = 11;
  localparam int HCFG_W      = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int NUM_SLOTS   = 3;
  localparam int SLOT_W      = 2;
  localparam int NUM_TAPS    = 3;
  localparam int QUEUE_DEPTH = 4;

  // Read taps of each line slot: center column, left neighbor, right neighbor.
  localparam int TAP_E = 0;
  localparam int TAP_D = 1;
  localparam int TAP_F = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic  en;
    slot_t slot;
    col_t  addr;
    pix_t  data;
  } wr_t;

  typedef struct packed {
    logic                    en;
    col_t [NUM_TAPS-1:0]     addr;
  } rd_t;

  typedef struct packed {
    row_t  row;
    col_t  col;
    logic  has_up;
    logic  has_up2;
    logic  bottom;
    logic  has_left;
    logic  right;
    slot_t s0;
    slot_t s1;
    slot_t s2;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/s2x_if.sv =====
`default_nettype none

interface s2x_pix_if import s2x_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface s2x_blk_if import s2x_pkg::*; ();
  logic valid;
  logic ready;
  col_t src_col;
  row_t src_row;
  pix_t top_left;
  pix_t top_right;
  pix_t bottom_left;
  pix_t bottom_right;
  logic last_of_run;

  modport source (output valid, output src_col, output src_row, output top_left,
                  output top_right, output bottom_left, output bottom_right,
                  output last_of_run, input ready);
  modport sink (input valid, input src_col, input src_row, input top_left,
                input top_right, input bottom_left, input bottom_right,
                input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/s2x_ram.sv =====
`default_nettype none

module s2x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/s2x_queue.sv =====
`default_nettype none

module s2x_queue import s2x_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d;
  logic [PTR_W-1:0]   rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/s2x_front.sv =====
`default_nettype none

module s2x_front import s2x_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  s2x_pix_if.sink          pix_i,
  input  logic             q_full_i,
  input  logic             q_empty_i,
  output logic             push_o,
  output entry_t           entry_o,
  output wr_t              wr_o
);

  col_t  wlast_q, wlast_d;
  row_t  hlast_q, hlast_d;
  col_t  col_q, col_d;
  row_t  row_q, row_d;
  slot_t slot_q, slot_d;
  slot_t s1, s2;
  logic  acc;
  logic  [WCFG_W-1:0] w_val;
  logic  [HCFG_W-1:0] h_val;

  // A row starts only once every queued block has read its neighbors, so the
  // slot being refilled is never still in use.
  assign pix_i.ready = !q_full_i && ((col_q != '0) || q_empty_i);
  assign acc         = pix_i.valid && pix_i.ready;

  assign s1 = (slot_q == '0) ? SLOT_W'(NUM_SLOTS - 1) : slot_q - 1'b1;
  assign s2 = (s1 == '0) ? SLOT_W'(NUM_SLOTS - 1) : s1 - 1'b1;

  always_comb begin
    entry_o.row      = row_q;
    entry_o.col      = col_q;
    entry_o.has_up   = (row_q != '0);
    entry_o.has_up2  = (row_q[ROW_W-1:1] != '0);
    entry_o.bottom   = (row_q == hlast_q);
    entry_o.has_left = (col_q != '0);
    entry_o.right    = (col_q == wlast_q);
    entry_o.s0       = slot_q;
    entry_o.s1       = s1;
    entry_o.s2       = s2;
  end

  assign push_o = acc && (entry_o.has_up || entry_o.bottom)
                      && (entry_o.has_left || entry_o.right);

  assign wr_o.en   = acc;
  assign wr_o.slot = slot_q;
  assign wr_o.addr = col_q;
  assign wr_o.data = pix_i.pixel;

  assign w_val = cfg_data_i[WCFG_W-1:0];
  assign h_val = cfg_data_i[HCFG_W-1:0];

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    col_d   = col_q;
    row_d   = row_q;
    slot_d  = slot_q;
    if (cfg_we_i) begin
      col_d  = '0;
      row_d  = '0;
      slot_d = '0;
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH: begin
          if (w_val == '0) begin
            wlast_d = '0;
          end else if (w_val > WCFG_W'(MAX_WIDTH)) begin
            wlast_d = COL_W'(MAX_WIDTH - 1);
          end else begin
            wlast_d = COL_W'(w_val - 1'b1);
          end
        end
        CFG_HEIGHT: begin
          if (h_val == '0) begin
            hlast_d = '0;
          end else if (h_val > HCFG_W'(MAX_HEIGHT)) begin
            hlast_d = ROW_W'(MAX_HEIGHT - 1);
          end else begin
            hlast_d = ROW_W'(h_val - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        if (row_q == hlast_q) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + 1'b1;
          slot_d = (slot_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= COL_W'(MAX_WIDTH - 1);
      hlast_q <= ROW_W'(1024 - 1);
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= '0;
    end else begin
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
      col_q   <= col_d;
      row_q   <= row_d;
      slot_q  <= slot_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/s2x_back.sv =====
`default_nettype none

module s2x_back import s2x_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   q_empty_i,
  output logic   pop_o,
  output rd_t    rd_o,
  input  pix_t   rdata_i [NUM_SLOTS][NUM_TAPS],
  s2x_blk_if.source blk_o
);

  logic  ri_q, ri_d;
  logic  ci_q, ci_d;
  logic  two_rows, two_cols, last_r, last_c, last;
  logic  up_blk, left_blk, issue, out_free;
  row_t  blk_row;
  col_t  blk_col;
  slot_t es, bs;

  logic  b_v_q, b_v_d;
  row_t  b_row_q;
  col_t  b_col_q;
  slot_t b_es_q, b_bs_q, b_hs_q;
  logic  b_last_q;

  logic  out_v_q, out_v_d;
  col_t  out_col_q;
  row_t  out_row_q;
  pix_t  out_tl_q, out_tr_q, out_bl_q, out_br_q;
  logic  out_last_q;

  pix_t  pe, pb, ph, pd, pf;
  logic  act;

  assign two_rows = head_i.has_up && head_i.bottom;
  assign two_cols = head_i.has_left && head_i.right;
  assign last_r   = !two_rows || ri_q;
  assign last_c   = !two_cols || ci_q;
  assign last     = last_r && last_c;
  assign up_blk   = head_i.has_up && !ri_q;
  assign left_blk = head_i.has_left && !ci_q;
  assign blk_row  = up_blk ? head_i.row - 1'b1 : head_i.row;
  assign blk_col  = left_blk ? head_i.col - 1'b1 : head_i.col;

  always_comb begin
    if (up_blk) begin
      es = head_i.s1;
      bs = head_i.has_up2 ? head_i.s2 : head_i.s1;
    end else begin
      es = head_i.s0;
      bs = head_i.has_up ? head_i.s1 : head_i.s0;
    end
  end

  assign out_free = !out_v_q || blk_o.ready;
  assign issue    = !q_empty_i && (!b_v_q || out_free);
  assign pop_o    = issue && last;

  assign rd_o.en          = issue;
  assign rd_o.addr[TAP_E] = blk_col;
  assign rd_o.addr[TAP_D] = (blk_col == '0) ? '0 : blk_col - 1'b1;
  assign rd_o.addr[TAP_F] = head_i.col;

  always_comb begin
    ri_d = ri_q;
    ci_d = ci_q;
    if (issue) begin
      if (last) begin
        ri_d = 1'b0;
        ci_d = 1'b0;
      end else if (last_c) begin
        ri_d = 1'b1;
        ci_d = 1'b0;
      end else begin
        ci_d = 1'b1;
      end
    end
  end

  assign b_v_d   = issue ? 1'b1 : (out_free ? 1'b0 : b_v_q);
  assign out_v_d = out_free ? b_v_q : out_v_q;

  assign pe  = rdata_i[b_es_q][TAP_E];
  assign pd  = rdata_i[b_es_q][TAP_D];
  assign pf  = rdata_i[b_es_q][TAP_F];
  assign pb  = rdata_i[b_bs_q][TAP_E];
  assign ph  = rdata_i[b_hs_q][TAP_E];
  assign act = (pb != ph) && (pd != pf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q    <= 1'b0;
      ci_q    <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      ri_q    <= ri_d;
      ci_q    <= ci_d;
      b_v_q   <= b_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_row_q  <= blk_row;
      b_col_q  <= blk_col;
      b_es_q   <= es;
      b_bs_q   <= bs;
      b_hs_q   <= head_i.s0;
      b_last_q <= last;
    end
    if (out_free && b_v_q) begin
      out_col_q  <= b_col_q;
      out_row_q  <= b_row_q;
      out_tl_q   <= (act && (pd == pb)) ? pd : pe;
      out_tr_q   <= (act && (pb == pf)) ? pf : pe;
      out_bl_q   <= (act && (pd == ph)) ? pd : pe;
      out_br_q   <= (act && (ph == pf)) ? pf : pe;
      out_last_q <= b_last_q;
    end
  end

  assign blk_o.valid        = out_v_q;
  assign blk_o.src_col      = out_col_q;
  assign blk_o.src_row      = out_row_q;
  assign blk_o.top_left     = out_tl_q;
  assign blk_o.top_right    = out_tr_q;
  assign blk_o.bottom_left  = out_bl_q;
  assign blk_o.bottom_right = out_br_q;
  assign blk_o.last_of_run  = out_last_q;

endmodule

`default_nettype wire

// ===== sv/scale2x_pixel_upscaler.sv =====
// A pixel beat that releases blocks passes through the block queue, the line-memory read register
// and the output register before its first block shows. Throughput: one pixel beat per cycle
// inside a row unless the block queue is full, one block beat per cycle on the output while it
// is ready; a pixel that releases two or four blocks holds the back end while they issue in turn.
// The first pixel of each row waits until the block queue has drained.
// Reset clears position, queue and output state and sets width and height to 1024;
// line memories are not cleared.
`default_nettype none

module scale2x_pixel_upscaler import s2x_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  s2x_pix_if.sink              pix_i,
  s2x_blk_if.source            blk_o
);

  logic   push, pop, q_full, q_empty;
  entry_t entry, head;
  wr_t    wr;
  rd_t    rd;
  pix_t   rdata [NUM_SLOTS][NUM_TAPS];

  s2x_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_i),
    .q_full_i   (q_full),
    .q_empty_i  (q_empty),
    .push_o     (push),
    .entry_o    (entry),
    .wr_o       (wr)
  );

  s2x_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
      s2x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (wr.en && (wr.slot == SLOT_W'(s))),
        .waddr_i (wr.addr),
        .wdata_i (wr.data),
        .re_i    (rd.en),
        .raddr_i (rd.addr[t]),
        .rdata_o (rdata[s][t])
      );
    end
  end

  s2x_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .rd_o      (rd),
    .rdata_i   (rdata),
    .blk_o     (blk_o)
  );

endmodule

`default_nettype wire

// ===== sv/s2x_checker.sv =====
`default_nettype none

module s2x_checker import s2x_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_i,
  input logic ready_i,
  input col_t col_i,
  input row_t row_i,
  input pix_t tl_i,
  input pix_t tr_i,
  input pix_t bl_i,
  input pix_t br_i,
  input logic last_i
);

  logic mid_run;

  assign mid_run = valid_i && ready_i && !last_i;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(col_i) && $stable(row_i) && $stable(tl_i)
      && $stable(tr_i) && $stable(bl_i) && $stable(br_i) && $stable(last_i))
    else $error("Stalled block beat changed.");

  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_run |=> valid_i)
    else $error("Blocks of one run were not delivered back to back.");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_run |=> (row_i == $past(row_i) && col_i == $past(col_i) + 1'b1)
      || (row_i == $past(row_i) + 1'b1))
    else $error("Blocks of one run left raster order.");

endmodule

bind scale2x_pixel_upscaler s2x_checker u_s2x_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (blk_o.valid),
  .ready_i (blk_o.ready),
  .col_i   (blk_o.src_col),
  .row_i   (blk_o.src_row),
  .tl_i    (blk_o.top_left),
  .tr_i    (blk_o.top_right),
  .bl_i    (blk_o.bottom_left),
  .br_i    (blk_o.bottom_right),
  .last_i  (blk_o.last_of_run)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  import s2x_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    col_t col;
    row_t row;
    pix_t tl;
    pix_t tr;
    pix_t bl;
    pix_t br;
    logic last;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;

  s2x_pix_if pix_bus ();
  s2x_blk_if blk_bus ();

  scale2x_pixel_upscaler u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .pix_i(pix_bus.sink), .blk_o(blk_bus.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pix_t pending_pixels[$];
  block_t expected_blocks[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;

  // Upscaler shadow state.
  pix_t rows_mem [0:NUM_SLOTS*MAX_WIDTH-1];
  int unsigned width_set = 1024, height_set = 1024, cur_row = 0, cur_col = 0;

  function automatic int unsigned eff_width();
    if (width_set == 0) return 1;
    if (width_set > MAX_WIDTH) return MAX_WIDTH;
    return width_set;
  endfunction

  function automatic int unsigned eff_height();
    if (height_set == 0) return 1;
    if (height_set > MAX_HEIGHT) return MAX_HEIGHT;
    return height_set;
  endfunction

  function automatic pix_t px(int unsigned r, int unsigned c);
    return rows_mem[(r % 3) * MAX_WIDTH + c];
  endfunction

  function automatic block_t scale_block(int unsigned r, int unsigned c, int unsigned w,
                                         int unsigned h, bit last);
    block_t b;
    pix_t e, up, dn, lf, rt;
    e = px(r, c);
    up = px(r == 0 ? 0 : r - 1, c);
    dn = px(r + 1 >= h ? h - 1 : r + 1, c);
    lf = px(r, c == 0 ? 0 : c - 1);
    rt = px(r, c + 1 >= w ? w - 1 : c + 1);
    b.col = col_t'(c);
    b.row = row_t'(r);
    b.tl = e; b.tr = e; b.bl = e; b.br = e;
    if (up != dn && lf != rt) begin
      b.tl = (lf == up) ? lf : e;
      b.tr = (up == rt) ? rt : e;
      b.bl = (lf == dn) ? lf : e;
      b.br = (dn == rt) ? rt : e;
    end
    b.last = last;
    return b;
  endfunction

  task automatic upscale_pixel(pix_t p);
    int unsigned w, h, r, c, nr, nc, n;
    int unsigned rl[2], cl[2];
    w = eff_width();
    h = eff_height();
    r = cur_row >= h ? 0 : cur_row;
    c = cur_col >= w ? 0 : cur_col;
    nr = 0; nc = 0; n = 0;
    rows_mem[(r % 3) * MAX_WIDTH + c] = p;
    if (r >= 1) begin rl[nr] = r - 1; nr++; end
    if (r == h - 1) begin rl[nr] = r; nr++; end
    if (c >= 1) begin cl[nc] = c - 1; nc++; end
    if (c == w - 1) begin cl[nc] = c; nc++; end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        n++;
        expected_blocks.push_back(scale_block(rl[i], cl[j], w, h, n == nr * nc));
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  // Pixel driver.
  int unsigned pix_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_bus.valid <= 1'b0;
      pix_bus.pixel <= '0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        upscale_pixel(pix_bus.pixel);
        void'(pending_pixels.pop_front());
      end
      if (!(pix_bus.valid && !pix_bus.ready)) begin
        if (pix_gap > 0) begin
          pix_gap--;
          pix_bus.valid <= 1'b0;
        end else if (pending_pixels.size() > 0 &&
                     !(pix_bus.valid && pix_bus.ready && pending_pixels.size() == 0)) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            pix_gap = $urandom_range(1, 6) - 1;
            pix_bus.valid <= 1'b0;
          end else begin
            pix_bus.valid <= 1'b1;
            pix_bus.pixel <= pending_pixels[0];
          end
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Block monitor.
  int unsigned blk_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_bus.ready <= 1'b0;
    end else begin
      if (blk_bus.valid && blk_bus.ready) begin
        block_t got, want;
        got = {blk_bus.src_col, blk_bus.src_row, blk_bus.top_left, blk_bus.top_right,
               blk_bus.bottom_left, blk_bus.bottom_right, blk_bus.last_of_run};
        if (expected_blocks.size() == 0) begin
          errors++;
          $display("%0t: unexpected block %h", $time, got);
        end else begin
          want = expected_blocks.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: block mismatch expected %h actual %h", $time, want, got);
          end
        end
      end
      if (blk_stall > 0) begin
        blk_stall--;
        blk_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        blk_stall = $urandom_range(1, 6) - 1;
        blk_bus.ready <= 1'b0;
      end else begin
        blk_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(val);
    if (idx == CFG_WIDTH) width_set = val & 12'h7FF;
    else height_set = val & 16'h1FFF;
    cur_row = 0;
    cur_col = 0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || expected_blocks.size() > 0 || pix_bus.valid)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic pix_t rand_pixel(int unsigned palette);
    if (palette == 0) return pix_t'($urandom);
    return pix_t'($urandom_range(0, palette - 1) * 16'h1111 ^ 16'hA5C3);
  endfunction

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned palette);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    for (int unsigned i = 0; i < eff_width() * eff_height(); i++)
      pending_pixels.push_back(rand_pixel(palette));
    drain();
  endtask

  initial begin
    int unsigned sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // Directed: field extremes, single pixel, zero sizes, a checker pattern.
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'h0000);
    drain();
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 3);
    for (int i = 0; i < 9; i++) pending_pixels.push_back(i % 2 ? 16'hFFFF : 16'h0000);
    for (int i = 0; i < 9; i++) pending_pixels.push_back(i == 4 ? 16'h1234 : 16'h5555);
    drain();
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 1);
    pending_pixels.push_back(16'h8001);
    pending_pixels.push_back(16'h7FFE);
    drain();
    // Width cut to the maximum with a partial row, then a column image.
    write_reg(CFG_WIDTH, 2047);
    write_reg(CFG_HEIGHT, 1);
    for (int i = 0; i < 24; i++) pending_pixels.push_back(rand_pixel(0));
    drain();
    run_frame(1, 40, 3);
    // Random frames of small sizes, few colors so that the rule matches.
    sent = 0;
    while (sent < 200) begin
      int unsigned w, h;
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      if (sent > 150) calm = 1'b1;
      run_frame(w, h, $urandom_range(0, 4));
      sent += w * h;
    end
    // Height extreme, and a mid-frame reconfiguration.
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 8191);
    for (int i = 0; i < 24; i++) pending_pixels.push_back(rand_pixel(2));
    drain();
    write_reg(CFG_HEIGHT, 4096);
    for (int i = 0; i < 5; i++) pending_pixels.push_back(rand_pixel(2));
    drain();
    run_frame(3, 2, 2);
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire
